[src/ssc_pkg.sv]
package ssc_pkg;

  localparam int COORD_BITS_DEF = 24;

  localparam logic [1:0] KIND_NORMAL   = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_INFINITE = 2'd2;

  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_PART = 2'd1;
  localparam logic [1:0] CLS_ALL  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       degen;
    logic       h_neg;
    logic       h_zero;
    logic       ah_neg;
    logic       ca_neg;
    logic       ca_zero;
    logic       cb_neg;
    logic       cb_zero;
  } flags_t;

  function automatic logic [1:0] classify(input flags_t f, input logic sd_neg,
                                          input logic sd_zero);
    logic h_le0;
    logic ah_ge0;
    logic t1_ge0;
    logic t2_le1;
    logic t1_le1;
    logic t2_ge0;
    logic [1:0] res;
    h_le0  = f.h_neg | f.h_zero;
    ah_ge0 = !f.ah_neg;
    t1_ge0 = h_le0 && !f.ca_neg;
    t2_le1 = ah_ge0 && !f.cb_neg;
    t1_le1 = ah_ge0 || f.cb_neg || f.cb_zero;
    t2_ge0 = h_le0 || f.ca_neg || f.ca_zero;
    case (f.kind)
      KIND_INFINITE: res = CLS_ALL;
      KIND_NORMAL: begin
        if (f.degen) begin
          res = (f.ca_neg || f.ca_zero) ? CLS_ALL : CLS_NONE;
        end else if (sd_neg) begin
          res = CLS_NONE;
        end else if (sd_zero) begin
          res = (h_le0 && ah_ge0) ? CLS_PART : CLS_NONE;
        end else if (t1_ge0 && t2_le1) begin
          res = CLS_ALL;
        end else if (t1_le1 && t2_ge0) begin
          res = CLS_PART;
        end else begin
          res = CLS_NONE;
        end
      end
      default: res = CLS_NONE;
    endcase
    return res;
  endfunction

endpackage

[src/ssc_wmul.sv]
module ssc_wmul #(
  parameter int OPW = 53
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [OPW-1:0]       a,
  input  logic [OPW-1:0]       b,
  output logic [2*OPW-1:0]     p
);

  localparam int HW = (OPW + 1) / 2;

  logic [2*HW-1:0] ax;
  logic [2*HW-1:0] bx;
  logic [2*HW-1:0] ll_r;
  logic [2*HW-1:0] lh_r;
  logic [2*HW-1:0] hl_r;
  logic [2*HW-1:0] hh_r;
  logic [2*HW:0]   mid;
  logic [4*HW-1:0] acc;
  logic [2*OPW-1:0] p_r;

  assign ax = (2*HW)'(a);
  assign bx = (2*HW)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= {{HW{1'b0}}, ax[HW-1:0]} * {{HW{1'b0}}, bx[HW-1:0]};
      lh_r <= {{HW{1'b0}}, ax[HW-1:0]} * {{HW{1'b0}}, bx[2*HW-1:HW]};
      hl_r <= {{HW{1'b0}}, ax[2*HW-1:HW]} * {{HW{1'b0}}, bx[HW-1:0]};
      hh_r <= {{HW{1'b0}}, ax[2*HW-1:HW]} * {{HW{1'b0}}, bx[2*HW-1:HW]};
    end
  end

  assign mid = {1'b0, lh_r} + {1'b0, hl_r};
  assign acc = {hh_r, ll_r} + ((4*HW)'(mid) << HW);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[2*OPW-1:0];
    end
  end

  assign p = p_r;

endmodule

[src/segment_sphere_classifier.sv]
// Throughput: one item per cycle while no stalled result holds the pipeline;
// seven items may be in flight at once.
// All stages advance together; a stalled result holds the whole pipeline.
// Reset (rst_n low, synchronous) clears every stage valid bit; data
// registers are not reset.
module segment_sphere_classifier
  import ssc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_sphere_kind,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic signed [COORD_BITS-1:0] in_center_z,
  input  logic [COORD_BITS-2:0]        in_radius,
  input  logic signed [COORD_BITS-1:0] in_seg_a_x,
  input  logic signed [COORD_BITS-1:0] in_seg_a_y,
  input  logic signed [COORD_BITS-1:0] in_seg_a_z,
  input  logic signed [COORD_BITS-1:0] in_seg_b_x,
  input  logic signed [COORD_BITS-1:0] in_seg_b_y,
  input  logic signed [COORD_BITS-1:0] in_seg_b_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_overlap_class
);

  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 2;
  localparam int MW   = SW + 1;
  localparam int RW   = COORD_BITS - 1;
  localparam int NSTG = 7;

  logic            en;
  logic [NSTG-1:0] vld_r;

  logic signed [COORD_BITS-1:0] cc [3];
  logic signed [COORD_BITS-1:0] pa [3];
  logic signed [COORD_BITS-1:0] pb [3];

  logic [1:0]           kind1_r;
  logic [RW-1:0]        r1_r;
  logic signed [DW-1:0] d1_r  [3];
  logic signed [DW-1:0] fa1_r [3];
  logic signed [DW-1:0] fb1_r [3];

  logic [1:0]           kind2_r;
  logic [2*RW-1:0]      r2_r;
  logic signed [PW-1:0] dd2_r [3];
  logic signed [PW-1:0] dh2_r [3];
  logic signed [PW-1:0] aa2_r [3];
  logic signed [PW-1:0] bb2_r [3];

  logic [1:0]           kind3_r;
  logic signed [SW-1:0] a3_r;
  logic signed [SW-1:0] h3_r;
  logic signed [MW-1:0] ca3_r;
  logic signed [MW-1:0] cb3_r;
  logic signed [SW-1:0] sa_nxt;
  logic signed [SW-1:0] sb_nxt;

  logic signed [MW-1:0] hx;
  logic signed [MW-1:0] ahx;
  logic [MW-1:0]        mh_nxt;
  logic [MW-1:0]        mca_nxt;
  flags_t               f4_nxt;
  flags_t               f4_r;
  flags_t               f5_r;
  flags_t               f6_r;
  logic [MW-1:0]        mh4_r;
  logic [MW-1:0]        mca4_r;
  logic [MW-1:0]        ma4_r;

  logic [2*MW-1:0]      hsq;
  logic [2*MW-1:0]      aca;
  logic                 sd_neg;
  logic                 sd_zero;
  logic [1:0]           cls_nxt;
  logic [1:0]           cls_r;

  assign en       = !(vld_r[NSTG-1] && out_stall);
  assign in_stall = !en;

  assign cc[0] = in_center_x;
  assign cc[1] = in_center_y;
  assign cc[2] = in_center_z;
  assign pa[0] = in_seg_a_x;
  assign pa[1] = in_seg_a_y;
  assign pa[2] = in_seg_a_z;
  assign pb[0] = in_seg_b_x;
  assign pb[1] = in_seg_b_y;
  assign pb[2] = in_seg_b_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= in_sphere_kind;
      r1_r    <= in_radius;
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= DW'(pb[i]) - DW'(pa[i]);
        fa1_r[i] <= DW'(pa[i]) - DW'(cc[i]);
        fb1_r[i] <= DW'(pb[i]) - DW'(cc[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind2_r <= kind1_r;
      r2_r    <= {{RW{1'b0}}, r1_r} * {{RW{1'b0}}, r1_r};
      for (int i = 0; i < 3; i++) begin
        dd2_r[i] <= PW'(d1_r[i]) * PW'(d1_r[i]);
        dh2_r[i] <= PW'(d1_r[i]) * PW'(fa1_r[i]);
        aa2_r[i] <= PW'(fa1_r[i]) * PW'(fa1_r[i]);
        bb2_r[i] <= PW'(fb1_r[i]) * PW'(fb1_r[i]);
      end
    end
  end

  assign sa_nxt = SW'(aa2_r[0]) + SW'(aa2_r[1]) + SW'(aa2_r[2]);
  assign sb_nxt = SW'(bb2_r[0]) + SW'(bb2_r[1]) + SW'(bb2_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      kind3_r <= kind2_r;
      a3_r    <= SW'(dd2_r[0]) + SW'(dd2_r[1]) + SW'(dd2_r[2]);
      h3_r    <= SW'(dh2_r[0]) + SW'(dh2_r[1]) + SW'(dh2_r[2]);
      ca3_r   <= MW'(sa_nxt) - $signed({{(MW-2*RW){1'b0}}, r2_r});
      cb3_r   <= MW'(sb_nxt) - $signed({{(MW-2*RW){1'b0}}, r2_r});
    end
  end

  assign hx      = MW'(h3_r);
  assign ahx     = MW'(a3_r) + hx;
  assign mh_nxt  = hx[MW-1] ? MW'(-hx) : MW'(hx);
  assign mca_nxt = ca3_r[MW-1] ? MW'(-ca3_r) : MW'(ca3_r);

  always_comb begin
    f4_nxt.kind    = kind3_r;
    f4_nxt.degen   = (a3_r == '0);
    f4_nxt.h_neg   = h3_r[SW-1];
    f4_nxt.h_zero  = (h3_r == '0);
    f4_nxt.ah_neg  = ahx[MW-1];
    f4_nxt.ca_neg  = ca3_r[MW-1];
    f4_nxt.ca_zero = (ca3_r == '0);
    f4_nxt.cb_neg  = cb3_r[MW-1];
    f4_nxt.cb_zero = (cb3_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_r   <= f4_nxt;
      mh4_r  <= mh_nxt;
      mca4_r <= mca_nxt;
      ma4_r  <= MW'(a3_r);
      f5_r   <= f4_r;
      f6_r   <= f5_r;
    end
  end

  ssc_wmul #(.OPW(MW)) u_hsq (
    .clk (clk),
    .en  (en),
    .a   (mh4_r),
    .b   (mh4_r),
    .p   (hsq)
  );

  ssc_wmul #(.OPW(MW)) u_aca (
    .clk (clk),
    .en  (en),
    .a   (ma4_r),
    .b   (mca4_r),
    .p   (aca)
  );

  always_comb begin
    if (f6_r.ca_neg) begin
      sd_neg  = 1'b0;
      sd_zero = (hsq == '0) && (aca == '0);
    end else begin
      sd_neg  = (hsq < aca);
      sd_zero = (hsq == aca);
    end
    cls_nxt = classify(f6_r, sd_neg, sd_zero);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r <= cls_nxt;
    end
  end

  assign out_valid         = vld_r[NSTG-1];
  assign out_overlap_class = cls_r;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_enter_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (en && in_valid) |=> vld_r[0])
    else $error("accepted item did not enter the first stage");

  a_tangent_never_all: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && f6_r.kind == KIND_NORMAL && !f6_r.degen && sd_zero)
      |-> cls_nxt != CLS_ALL)
    else $error("tangent segment classified as entirely inside");

  a_infinite_all: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && f6_r.kind == KIND_INFINITE) |-> cls_nxt == CLS_ALL)
    else $error("infinite sphere did not give entirely inside");

  a_point_not_part: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && f6_r.kind == KIND_NORMAL && f6_r.degen) |-> cls_nxt != CLS_PART)
    else $error("degenerate segment classified as partly inside");

endmodule

[tb/segment_sphere_classifier_tb.sv]
module segment_sphere_classifier_tb
  import ssc_pkg::*;
;

  localparam int CB = COORD_BITS_DEF;
  localparam int ONE = 4096;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES = 7;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic [1:0]           kind;
    logic signed [CB-1:0] cx, cy, cz;
    logic [CB-2:0]        radius;
    logic signed [CB-1:0] ax, ay, az;
    logic signed [CB-1:0] bx, by, bz;
  } seg_item_t;

  class overlap_scoreboard;
    logic [1:0] expected_classes[$];
    int         accepted;
    int         mismatches;
    int         class_seen[3];

    function wide_t dot3(input wide_t p[3], input wide_t q[3]);
      return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    function logic [1:0] predict_overlap(input seg_item_t it);
      wide_t c[3], a[3], b[3], d[3], fa[3], fb[3];
      wide_t r2, ca, cb, len2, h, disc;
      logic  h_le0, ah_ge0, t1_ge0, t2_le1, t1_le1, t2_ge0;
      c[0] = wide_t'(it.cx); c[1] = wide_t'(it.cy); c[2] = wide_t'(it.cz);
      a[0] = wide_t'(it.ax); a[1] = wide_t'(it.ay); a[2] = wide_t'(it.az);
      b[0] = wide_t'(it.bx); b[1] = wide_t'(it.by); b[2] = wide_t'(it.bz);
      for (int i = 0; i < 3; i++) begin
        d[i]  = b[i] - a[i];
        fa[i] = a[i] - c[i];
        fb[i] = b[i] - c[i];
      end
      if (it.kind == KIND_INFINITE) return CLS_ALL;
      if (it.kind != KIND_NORMAL) return CLS_NONE;
      r2 = wide_t'(it.radius);
      r2 = r2 * r2;
      ca = dot3(fa, fa) - r2;
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) return (ca <= 0) ? CLS_ALL : CLS_NONE;
      cb   = dot3(fb, fb) - r2;
      len2 = dot3(d, d);
      h    = dot3(d, fa);
      disc = h * h - len2 * ca;
      h_le0  = (h <= 0);
      ah_ge0 = (len2 + h >= 0);
      if (disc < 0) return CLS_NONE;
      if (disc == 0) return (h_le0 && ah_ge0) ? CLS_PART : CLS_NONE;
      t1_ge0 = h_le0 && (ca >= 0);
      t2_le1 = ah_ge0 && (cb >= 0);
      t1_le1 = ah_ge0 || (cb <= 0);
      t2_ge0 = h_le0 || (ca <= 0);
      if (t1_ge0 && t2_le1) return CLS_ALL;
      if (t1_le1 && t2_ge0) return CLS_PART;
      return CLS_NONE;
    endfunction

    function void note_item(input seg_item_t it);
      expected_classes.push_back(predict_overlap(it));
      accepted++;
    endfunction

    function void check_class(input logic [1:0] got);
      logic [1:0] want;
      if (expected_classes.size() == 0) begin
        mismatches++;
        $display("%0t: result %0d arrived with no item pending", $time, got);
        return;
      end
      want = expected_classes.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: overlap_class mismatch: expected %0d, got %0d", $time, want, got);
      end else if (got <= CLS_ALL) begin
        class_seen[got]++;
      end
    endfunction

    function int pending();
      return expected_classes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_sphere_kind;
  logic signed [CB-1:0] in_center_x, in_center_y, in_center_z;
  logic [CB-2:0]        in_radius;
  logic signed [CB-1:0] in_seg_a_x, in_seg_a_y, in_seg_a_z;
  logic signed [CB-1:0] in_seg_b_x, in_seg_b_y, in_seg_b_z;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_overlap_class;

  overlap_scoreboard sb = new();
  seg_item_t         taken_item;
  int                sender_gap_max;
  int                receiver_stall_max;
  int                hold_off_cycles;

  segment_sphere_classifier dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sphere_kind    (in_sphere_kind),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_center_z       (in_center_z),
    .in_radius         (in_radius),
    .in_seg_a_x        (in_seg_a_x),
    .in_seg_a_y        (in_seg_a_y),
    .in_seg_a_z        (in_seg_a_z),
    .in_seg_b_x        (in_seg_b_x),
    .in_seg_b_y        (in_seg_b_y),
    .in_seg_b_z        (in_seg_b_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_overlap_class (out_overlap_class)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("Some tests failed");
    $finish;
  end

  function automatic seg_item_t mk(input logic [1:0] kind, input int cx, input int cy,
                                   input int cz, input int r, input int ax, input int ay,
                                   input int az, input int bx, input int by, input int bz);
    seg_item_t it;
    it.kind = kind;
    it.cx = CB'(cx); it.cy = CB'(cy); it.cz = CB'(cz);
    it.radius = (CB - 1)'(r);
    it.ax = CB'(ax); it.ay = CB'(ay); it.az = CB'(az);
    it.bx = CB'(bx); it.by = CB'(by); it.bz = CB'(bz);
    return it;
  endfunction

  function automatic int srand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic seg_item_t rand_item();
    int         pick, sc, r, span;
    int         cx, cy, cz, ax, ay, az, bx, by, bz;
    logic [1:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      return mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom);
    kind = KIND_NORMAL;
    if (pick < 18) begin
      case ($urandom_range(0, 2))
        0:       kind = KIND_EMPTY;
        1:       kind = KIND_INFINITE;
        default: kind = KIND_UNUSED;
      endcase
    end
    sc = ($urandom_range(0, 3) == 0) ? 16 : (1 << 20);
    cx = srand(sc); cy = srand(sc); cz = srand(sc);
    r = $urandom_range(0, sc);
    span = 2 * r + 1;
    ax = cx + srand(span); ay = cy + srand(span); az = cz + srand(span);
    bx = cx + srand(span); by = cy + srand(span); bz = cz + srand(span);
    case ($urandom_range(0, 5))
      1: begin
        bx = ax; by = ay; bz = az;
      end
      2: begin
        ay = ($urandom_range(0, 1) != 0) ? cy + r : cy - r;
        by = ay;
        az = cz;
        bz = cz;
      end
      3: begin
        ax = ($urandom_range(0, 1) != 0) ? cx + r : cx - r;
        ay = cy;
        az = cz;
      end
      4: begin
        ax = cx + srand(r / 2); ay = cy + srand(r / 2); az = cz + srand(r / 2);
        bx = cx + srand(r / 2); by = cy + srand(r / 2); bz = cz + srand(r / 2);
      end
      5: begin
        ax = srand(1 << 22); ay = srand(1 << 22); az = srand(1 << 22);
        bx = srand(1 << 22); by = srand(1 << 22); bz = srand(1 << 22);
      end
      default: ;
    endcase
    return mk(kind, cx, cy, cz, r, ax, ay, az, bx, by, bz);
  endfunction

  task automatic send_item(input seg_item_t it);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sphere_kind <= it.kind;
    in_center_x    <= it.cx;
    in_center_y    <= it.cy;
    in_center_z    <= it.cz;
    in_radius      <= it.radius;
    in_seg_a_x     <= it.ax;
    in_seg_a_y     <= it.ay;
    in_seg_a_z     <= it.az;
    in_seg_b_x     <= it.bx;
    in_seg_b_y     <= it.by;
    in_seg_b_z     <= it.bz;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      taken_item.kind   = in_sphere_kind;
      taken_item.cx     = in_center_x;
      taken_item.cy     = in_center_y;
      taken_item.cz     = in_center_z;
      taken_item.radius = in_radius;
      taken_item.ax     = in_seg_a_x;
      taken_item.ay     = in_seg_a_y;
      taken_item.az     = in_seg_a_z;
      taken_item.bx     = in_seg_b_x;
      taken_item.by     = in_seg_b_y;
      taken_item.bz     = in_seg_b_z;
      sb.note_item(taken_item);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_class(out_overlap_class);
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        n = $urandom_range(0, receiver_stall_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int snd_max[NUM_PHASES];
    int rcv_max[NUM_PHASES];
    snd_max = '{8, 0, 3, 0, 8, 0, 5};
    rcv_max = '{8, 0, 0, 8, 3, 0, 5};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sphere_kind = KIND_NORMAL;
    in_center_x = '0; in_center_y = '0; in_center_z = '0;
    in_radius = '0;
    in_seg_a_x = '0; in_seg_a_y = '0; in_seg_a_z = '0;
    in_seg_b_x = '0; in_seg_b_y = '0; in_seg_b_z = '0;
    sender_gap_max = 8;
    receiver_stall_max = 8;
    hold_off_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(mk(KIND_INFINITE, 100, -200, 300, 5000, 1, 2, 3, 9999, 9999, 9999));
    send_item(mk(KIND_EMPTY, 0, 0, 0, 8388607, 0, 0, 0, 1, 1, 1));
    send_item(mk(KIND_UNUSED, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0));
    send_item(mk(KIND_NORMAL, 5, 5, 5, 0, 5, 5, 5, 5, 5, 5));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, ONE, 0, 0, ONE, 0, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, ONE + 1, 0, 0, ONE + 1, 0, 0));
    send_item(mk(KIND_NORMAL, -8388608, -8388608, -8388608, 8388607,
                 8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
    send_item(mk(KIND_NORMAL, 8388607, 8388607, 8388607, 0,
                 -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, -2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, -ONE, ONE, 0, ONE, ONE, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, ONE, ONE, 0, 3 * ONE, ONE, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, -ONE / 2, 0, 0, 0, ONE / 2, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, 0, 0, 0, 2 * ONE, 0, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, -2 * ONE, 0, 0, 2 * ONE, 0, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, -3 * ONE, 0, 0, -2 * ONE, 0, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, 0, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, -ONE, 0, 0, ONE, 0, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, 0, -1, 0, 0, 1, 0, 0));
    send_item(mk(KIND_NORMAL, 0, 0, 0, ONE, ONE, 0, 0, 2 * ONE, 0, 0));
    send_item(mk(KIND_NORMAL, -1, -1, -1, 8388607, -1, -1, -1, -1, -1, -1));
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_gap_max = snd_max[p];
      receiver_stall_max = rcv_max[p];
      if (p == 1) hold_off_cycles = 80;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_item(rand_item());
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (16) @(posedge clk);
    $display("Checked %0d items: %0d miss, %0d partial, %0d inside, %0d mismatches",
             sb.accepted, sb.class_seen[CLS_NONE], sb.class_seen[CLS_PART],
             sb.class_seen[CLS_ALL], sb.mismatches);
    $display("Covered corner geometry, tangents, point segments and long output stalls");
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
